[hdl/rc4_pkg.sv]
// Shared constants and types for the RC4 stream cipher.
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int STATE_SIZE_DEF = 256;
   localparam int MAX_KEY_DEF    = 256;
   localparam int CMD_W          = 2;
   localparam int BYTE_W         = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_KEY_LOAD = 2'd0,
      CMD_SCHEDULE = 2'd1,
      CMD_CIPHER   = 2'd2,
      CMD_NONE     = 2'd3
   } command_type;

   typedef struct packed {
      logic              load;
      logic [BYTE_W-1:0] load_byte;
      logic              restart;
      logic              advance;
   } key_ctrl_type;

endpackage

[hdl/rc4_key_store.sv]
// Key byte store with length tracking and cyclic read-out for the key schedule.
`timescale 1ns / 1ps

module rc4_key_store #(
   parameter int STATE_SIZE    = rc4_pkg::STATE_SIZE_DEF,
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rc4_pkg::key_ctrl_type         ctrl,
   output logic [$clog2(STATE_SIZE)-1:0] key_byte
);
   import rc4_pkg::*;

   localparam int PW  = $clog2(STATE_SIZE);
   localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
   localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   logic [PW-1:0]  key_mem [MAX_KEY_BYTES];
   logic [PW-1:0]  rd_ff;
   logic [KLW-1:0] len_ff, len_in;
   logic [KLW-1:0] kidx_ff, kidx_in;
   logic           fresh_ff, fresh_in;
   logic [KLW-1:0] len_base;
   logic [KLW-1:0] kidx_inc;
   logic           wr_en;

   function automatic logic [PW-1:0] reduce(input logic [BYTE_W-1:0] v);
      logic [16:0] r;
      logic [16:0] d;
      r = 17'(v);
      for (int k = 7; k >= 0; k--) begin
         d = 17'(STATE_SIZE) << k;
         if (r >= d) r = r - d;
      end
      return r[PW-1:0];
   endfunction

   always_comb begin
      len_base = fresh_ff ? '0 : len_ff;
      kidx_inc = KLW'(kidx_ff + 1'b1);
      len_in   = len_ff;
      fresh_in = fresh_ff;
      kidx_in  = kidx_ff;
      wr_en    = 1'b0;
      if (ctrl.load) begin
         fresh_in = 1'b0;
         len_in   = len_base;
         if (len_base < KLW'(MAX_KEY_BYTES)) begin
            wr_en  = 1'b1;
            len_in = KLW'(len_base + 1'b1);
         end
      end
      if (ctrl.restart) begin
         fresh_in = 1'b1;
         kidx_in  = '0;
      end else if (ctrl.advance && len_ff != '0) begin
         kidx_in = (kidx_inc == len_ff) ? '0 : kidx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         fresh_ff <= 1'b1;
         kidx_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         fresh_ff <= fresh_in;
         kidx_ff  <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) key_mem[len_base[KAW-1:0]] <= reduce(ctrl.load_byte);
      if (ctrl.advance) rd_ff <= key_mem[kidx_ff[KAW-1:0]];
   end

   assign key_byte = (len_ff == '0) ? '0 : rd_ff;

endmodule

[hdl/rc4_stream_cipher.sv]
// Top level of the RC4 stream cipher: sequencer and permutation RAM.
`timescale 1ns / 1ps

// RC4 stream cipher. Command 0 appends a key byte (the first byte after a schedule
// starts a new key, bytes past MAX_KEY_BYTES are dropped). Command 1 runs the key
// schedule: it refills the table with identity, then takes each entry through KS_READ,
// KS_J, KS_SWAP and KS_DONE. Command 2 ciphers a byte: three dependent reads and a
// two-entry swap go through the single read port and single write port of the
// permutation RAM. req_ready is low during both commands. The result sits in an output
// register, so a new byte is taken while it waits. After reset the table is filled
// with identity with req_ready low.
module rc4_stream_cipher #(
   parameter int STATE_SIZE    = rc4_pkg::STATE_SIZE_DEF,
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rc4_pkg::CMD_W-1:0]    req_command,
   input  logic [rc4_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]   rsp_out_byte
);
   import rc4_pkg::*;

   localparam int PW = $clog2(STATE_SIZE);
   localparam int SW = PW + 2;
   localparam logic [PW-1:0] LAST = PW'(STATE_SIZE - 1);

   typedef enum logic [9:0] {
      ST_INIT     = 10'b0000000001,
      ST_IDLE     = 10'b0000000010,
      ST_GEN_J    = 10'b0000000100,
      ST_GEN_SWAP = 10'b0000001000,
      ST_GEN_OUT  = 10'b0000010000,
      ST_FILL     = 10'b0000100000,
      ST_KS_READ  = 10'b0001000000,
      ST_KS_J     = 10'b0010000000,
      ST_KS_SWAP  = 10'b0100000000,
      ST_KS_DONE  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     i_ff, i_in;
   logic [PW-1:0]     j_ff, j_in;
   logic [PW-1:0]     n_ff, n_in;
   logic [PW-1:0]     pa_ff, pa_in;
   logic [PW-1:0]     pb_ff, pb_in;
   logic [PW-1:0]     t_ff, t_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_out_byte_ff, rsp_out_byte_in;

   logic [PW-1:0]     perm_mem [STATE_SIZE];
   logic [PW-1:0]     prd_ff;
   logic              re, we;
   logic [PW-1:0]     ra, wa, wd;
   logic [PW-1:0]     ks;
   logic [PW-1:0]     key_byte;
   key_ctrl_type      key_ctrl;
   logic              accept;

   function automatic logic [PW-1:0] inc_mod(input logic [PW-1:0] a);
      return (a == LAST) ? '0 : PW'(a + 1'b1);
   endfunction

   function automatic logic [PW-1:0] add_mod(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                            input logic [PW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b) + SW'(c);
      if (s >= SW'(STATE_SIZE)) s = s - SW'(STATE_SIZE);
      if (s >= SW'(STATE_SIZE)) s = s - SW'(STATE_SIZE);
      return s[PW-1:0];
   endfunction

   rc4_key_store #(
      .STATE_SIZE    (STATE_SIZE),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_key_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (key_ctrl),
      .key_byte (key_byte)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

   always_comb begin
      state_in        = state_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      n_in            = n_ff;
      pa_in           = pa_ff;
      pb_in           = pb_ff;
      t_in            = t_ff;
      data_in         = data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_out_byte_in = rsp_out_byte_ff;
      re              = 1'b0;
      we              = 1'b0;
      ra              = '0;
      wa              = '0;
      wd              = '0;
      ks              = prd_ff;
      key_ctrl        = '0;
      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            we   = 1'b1;
            wa   = n_ff;
            wd   = n_ff;
            n_in = inc_mod(n_ff);
            if (n_ff == LAST) state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_KS_READ;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_KEY_LOAD: begin
                     key_ctrl.load      = 1'b1;
                     key_ctrl.load_byte = req_data_byte;
                  end
                  CMD_SCHEDULE: begin
                     key_ctrl.restart = 1'b1;
                     n_in             = '0;
                     j_in             = '0;
                     state_in         = ST_FILL;
                  end
                  CMD_CIPHER: begin
                     i_in     = inc_mod(i_ff);
                     re       = 1'b1;
                     ra       = i_in;
                     data_in  = req_data_byte;
                     state_in = ST_GEN_J;
                  end
                  default: ;
               endcase
            end
         end
         ST_GEN_J: begin
            pa_in    = prd_ff;
            j_in     = add_mod(j_ff, prd_ff, '0);
            re       = 1'b1;
            ra       = j_in;
            state_in = ST_GEN_SWAP;
         end
         ST_GEN_SWAP: begin
            pb_in    = prd_ff;
            we       = 1'b1;
            wa       = i_ff;
            wd       = prd_ff;
            t_in     = add_mod(pa_ff, prd_ff, '0);
            re       = 1'b1;
            ra       = t_in;
            state_in = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            we = 1'b1;
            wa = j_ff;
            wd = pa_ff;
            if (t_ff == j_ff)      ks = pa_ff;
            else if (t_ff == i_ff) ks = pb_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_out_byte_in = data_ff ^ BYTE_W'(ks);
               state_in        = ST_IDLE;
            end
         end
         ST_KS_READ: begin
            re               = 1'b1;
            ra               = n_ff;
            key_ctrl.advance = 1'b1;
            state_in         = ST_KS_J;
         end
         ST_KS_J: begin
            pa_in    = prd_ff;
            j_in     = add_mod(j_ff, prd_ff, key_byte);
            re       = 1'b1;
            ra       = j_in;
            state_in = ST_KS_SWAP;
         end
         ST_KS_SWAP: begin
            pb_in    = prd_ff;
            we       = 1'b1;
            wa       = n_ff;
            wd       = prd_ff;
            state_in = ST_KS_DONE;
         end
         ST_KS_DONE: begin
            we   = 1'b1;
            wa   = j_ff;
            wd   = pa_ff;
            n_in = inc_mod(n_ff);
            if (n_ff == LAST) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff           <= pa_in;
      pb_ff           <= pb_in;
      t_ff            <= t_in;
      data_ff         <= data_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
   end

   always_ff @(posedge clock) begin
      if (we) perm_mem[wa] <= wd;
      if (re) prd_ff <= perm_mem[ra];
   end

endmodule

[hdl/rc4_checker.sv]
// Port-level checks for the RC4 stream cipher and their binding to the top level.
`timescale 1ns / 1ps

module rc4_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [rc4_pkg::CMD_W-1:0]  req_command,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rc4_pkg::BYTE_W-1:0] rsp_out_byte
);
   import rc4_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("result dropped or changed while stalled");

   init_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("request taken during table init");

   busy_after_long: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_command == CMD_CIPHER || req_command == CMD_SCHEDULE)
      |=> !req_ready)
      else $error("request taken while cipher or schedule in progress");

   key_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command == CMD_KEY_LOAD |=> req_ready)
      else $error("key byte transfer stalled the input");

   no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command != CMD_CIPHER && !rsp_valid |=> !rsp_valid)
      else $error("result without a cipher transfer");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);

[tb/rc4_stream_cipher_tb.sv]
// Self-checking testbench for the RC4 stream cipher: queued stimulus, keystream prediction.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
   import rc4_pkg::*;

   localparam int TABLE_SIZE  = 256;
   localparam int KEY_CAP     = 256;
   localparam int ITEM_GOAL   = 1100;
   localparam int CALM_TAIL   = 150;
   localparam int SETTLE      = 5 * TABLE_SIZE + 20;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      command_type cmd;
      logic [7:0]  data;
      bit          drain;
   } cmd_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = CMD_NONE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;

   cmd_item_type cmd_backlog[$];
   logic [7:0]   keystream_due[$];

   logic [7:0] sbox[TABLE_SIZE];
   logic [7:0] key_bytes[KEY_CAP];
   int         key_count;
   bit         key_restart;
   logic [7:0] idx_i, idx_j;

   int send_gap = 0;
   int hold_gap = 0;
   int failures = 0;
   int cycle_count = 0;
   int loads = 0, dropped = 0, schedules = 0, ciphers = 0, ignored = 0, checked = 0;
   int live_items = 0;

   rc4_stream_cipher DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic apply_command(input command_type cmd, input logic [7:0] data);
      logic [7:0] j, t, tmp, kb;
      int n;
      case (cmd)
         CMD_KEY_LOAD: begin
            if (key_restart) begin
               key_count = 0;
               key_restart = 1'b0;
            end
            if (key_count < KEY_CAP) begin
               key_bytes[key_count] = data;
               key_count++;
            end else begin
               dropped++;
            end
            loads++;
         end
         CMD_SCHEDULE: begin
            for (n = 0; n < TABLE_SIZE; n++) sbox[n] = 8'(n);
            j = 8'd0;
            for (n = 0; n < TABLE_SIZE; n++) begin
               kb = (key_count == 0) ? 8'd0 : key_bytes[n % key_count];
               j = j + sbox[n] + kb;
               tmp = sbox[n];
               sbox[n] = sbox[j];
               sbox[j] = tmp;
            end
            idx_i = 8'd0;
            idx_j = 8'd0;
            key_restart = 1'b1;
            schedules++;
         end
         CMD_CIPHER: begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            tmp = sbox[idx_i];
            sbox[idx_i] = sbox[idx_j];
            sbox[idx_j] = tmp;
            t = sbox[idx_i] + sbox[idx_j];
            keystream_due.push_back(data ^ sbox[t]);
            ciphers++;
         end
         default: ignored++;
      endcase
   endtask

   task automatic queue_item(input command_type cmd, input logic [7:0] data, input bit drain);
      cmd_item_type item;
      item.cmd = cmd;
      item.data = data;
      item.drain = drain;
      cmd_backlog.push_back(item);
      if (cmd != CMD_NONE) live_items++;
   endtask

   task automatic queue_noise();
      if ($urandom_range(0, 24) == 0) queue_item(CMD_NONE, 8'($urandom), 1'b0);
   endtask

   always @(posedge clock) begin : driver
      cmd_item_type nxt;
      bit show;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         show = req_valid;
         if (req_valid && req_ready) begin
            apply_command(command_type'(req_command), req_data_byte);
            show = 1'b0;
         end
         if (!show) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
            end else if (cmd_backlog.size() != 0
                         && !(cmd_backlog[0].drain && keystream_due.size() != 0)) begin
               if (cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(0, 8);
               end else begin
                  nxt = cmd_backlog.pop_front();
                  req_command <= nxt.cmd;
                  req_data_byte <= nxt.data;
                  show = 1'b1;
               end
            end
         end
         req_valid <= show;
      end
   end

   always @(posedge clock) begin : monitor
      logic [7:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (keystream_due.size() == 0) begin
               $error("out_byte: no transfer expected, actual %02h", rsp_out_byte);
               failures++;
            end else begin
               want = keystream_due.pop_front();
               if (want !== rsp_out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h", want, rsp_out_byte);
                  failures++;
               end
            end
            checked++;
         end
         if (hold_gap != 0) begin
            rsp_ready <= 1'b0;
            hold_gap <= hold_gap - 1;
         end else if (cmd_backlog.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            hold_gap <= $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles", cycle_count);
         $display("[rc4_stream_cipher] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int n, k, klen, nbytes, seq;
      for (n = 0; n < TABLE_SIZE; n++) sbox[n] = 8'(n);
      key_count = 0;
      key_restart = 1'b1;
      idx_i = 8'd0;
      idx_j = 8'd0;

      queue_item(CMD_CIPHER, 8'h00, 1'b0);
      queue_item(CMD_CIPHER, 8'hFF, 1'b0);
      queue_item(CMD_NONE, 8'hA5, 1'b0);
      queue_item(CMD_SCHEDULE, 8'hFF, 1'b1);
      queue_item(CMD_CIPHER, 8'h00, 1'b0);
      queue_item(CMD_CIPHER, 8'hFF, 1'b0);
      queue_item(CMD_KEY_LOAD, 8'hFF, 1'b0);
      queue_item(CMD_KEY_LOAD, 8'h00, 1'b0);
      queue_item(CMD_KEY_LOAD, 8'h01, 1'b0);
      queue_item(CMD_SCHEDULE, 8'h00, 1'b0);
      queue_item(CMD_CIPHER, 8'h00, 1'b0);
      queue_item(CMD_CIPHER, 8'hFF, 1'b0);
      queue_item(CMD_CIPHER, 8'h5A, 1'b0);
      queue_item(CMD_CIPHER, 8'hA5, 1'b0);
      queue_item(CMD_SCHEDULE, 8'h55, 1'b0);
      queue_item(CMD_CIPHER, 8'h0F, 1'b0);
      queue_item(CMD_CIPHER, 8'hF0, 1'b0);
      queue_item(CMD_KEY_LOAD, 8'h80, 1'b0);
      queue_item(CMD_SCHEDULE, 8'hAA, 1'b0);
      queue_item(CMD_CIPHER, 8'h00, 1'b0);
      queue_item(CMD_NONE, 8'h00, 1'b0);
      queue_item(CMD_CIPHER, 8'hFF, 1'b0);
      queue_item(CMD_NONE, 8'hFF, 1'b0);

      for (k = 0; k < KEY_CAP + 6; k++) queue_item(CMD_KEY_LOAD, 8'($urandom), 1'b0);
      queue_item(CMD_SCHEDULE, 8'($urandom), 1'b0);
      for (k = 0; k < 24; k++) queue_item(CMD_CIPHER, 8'($urandom), 1'b0);

      seq = 0;
      while (live_items < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0:       klen = 0;
            1:       klen = $urandom_range(17, 40);
            default: klen = $urandom_range(1, 16);
         endcase
         for (k = 0; k < klen; k++) begin
            queue_item(CMD_KEY_LOAD, 8'($urandom), (k == 0) && (seq % 8 == 3));
            queue_noise();
         end
         queue_item(CMD_SCHEDULE, 8'($urandom), (klen == 0) && (seq % 8 == 3));
         nbytes = $urandom_range(4, 40);
         for (k = 0; k < nbytes; k++) begin
            queue_item(CMD_CIPHER, 8'($urandom), 1'b0);
            queue_noise();
            if ($urandom_range(0, 39) == 0) queue_item(CMD_KEY_LOAD, 8'($urandom), 1'b0);
         end
         seq++;
      end
      for (k = 0; k < 8; k++) queue_item(CMD_CIPHER, 8'($urandom), 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (cmd_backlog.size() != 0 || req_valid);
      while (keystream_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d key loads (%0d past a full store), %0d schedules, %0d ignored",
               loads, dropped, schedules, ignored);
      $display("ciphered %0d bytes, checked %0d output transfers", ciphers, checked);
      if (failures == 0) begin
         $display("[rc4_stream_cipher] OK");
      end else begin
         $display("[rc4_stream_cipher] ERROR");
      end
      $finish;
   end

endmodule
